// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the stall lock detector RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion of an arbitrary property, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/sld_pkg.sv -----
// Types and constants for the stall lock detector.
// No dependencies; imported by every module of the block.
package sld_pkg;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MS       = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_DELTA_MAX = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_MS         = 4'd3;

   // Register reset values.
   localparam logic [14:0] SPEED_THRESHOLD_RST = 15'd50;
   localparam logic [15:0] WINDOW_MS_RST       = 16'd200;
   localparam logic [15:0] ANGLE_DELTA_MAX_RST = 16'd50;
   localparam logic [15:0] HOLD_MS_RST         = 16'd500;

   // Tracking status codes reported with each result.
   localparam logic [1:0] TRACK_IDLE   = 2'd0;
   localparam logic [1:0] TRACK_ARMED  = 2'd1;
   localparam logic [1:0] TRACK_STABLE = 2'd2;

   // One telemetry sample.
   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [23:0] angle;
      logic        [31:0] now_ms;
      logic               clear;
   } req_type;

   // One detector result.
   typedef struct packed {
      logic       locked;
      logic [1:0] track_status;
   } rsp_type;

   // Current configuration as seen by the detector core.
   typedef struct packed {
      logic [14:0] speed_threshold;
      logic [15:0] window_ms;
      logic [15:0] angle_delta_max;
      logic [15:0] hold_ms;
   } cfg_type;

endpackage

// ----- hw/rtl/sld_csr.sv -----
// Configuration register file of the stall lock detector.
// Depends on sld_pkg for the register indexes, reset values and cfg_type.
module sld_csr
   import sld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken at once.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index; writes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_THRESHOLD: cfg_in.speed_threshold = csr_data[14:0];
            CSR_WINDOW_MS:       cfg_in.window_ms       = csr_data;
            CSR_ANGLE_DELTA_MAX: cfg_in.angle_delta_max = csr_data;
            CSR_HOLD_MS:         cfg_in.hold_ms         = csr_data;
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_threshold <= SPEED_THRESHOLD_RST;
         cfg_ff.window_ms       <= WINDOW_MS_RST;
         cfg_ff.angle_delta_max <= ANGLE_DELTA_MAX_RST;
         cfg_ff.hold_ms         <= HOLD_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/sld_core.sv -----
// Tracking state and per-sample decision logic of the stall lock detector.
// Depends on sld_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sld_core
   import sld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic               armed_ff;
   logic               armed_in;
   logic               stable_ff;
   logic               stable_in;
   logic        [31:0] start_time_ff;
   logic        [31:0] start_time_in;
   logic signed [23:0] start_angle_ff;
   logic signed [23:0] start_angle_in;

   logic signed [16:0] speed_wide;
   logic        [16:0] speed_mag;
   logic        [31:0] elapsed;
   logic signed [24:0] angle_diff;
   logic        [24:0] angle_mag;
   logic               too_fast;
   logic               window_done;
   logic               angle_ok;
   logic               hold_done;
   logic               locked;

   // Magnitudes and elapsed time; the time difference wraps modulo 2^32.
   assign speed_wide  = {item.speed[15], item.speed};
   assign speed_mag   = speed_wide[16] ? 17'(-speed_wide) : 17'(speed_wide);
   assign too_fast    = speed_mag > {2'b00, cfg.speed_threshold};
   assign elapsed     = item.now_ms - start_time_ff;
   assign window_done = elapsed >= {16'd0, cfg.window_ms};
   assign hold_done   = elapsed >= {16'd0, cfg.hold_ms};
   assign angle_diff  = {item.angle[23], item.angle} - {start_angle_ff[23], start_angle_ff};
   assign angle_mag   = angle_diff[24] ? 25'(-angle_diff) : 25'(angle_diff);
   assign angle_ok    = angle_mag <= {9'd0, cfg.angle_delta_max};

   // Next tracking state and the lock decision for this beat.
   always_comb begin
      armed_in       = armed_ff;
      stable_in      = stable_ff;
      start_time_in  = start_time_ff;
      start_angle_in = start_angle_ff;
      locked         = 1'b0;
      priority if (item.clear) begin
         armed_in       = 1'b0;
         stable_in      = 1'b0;
         start_time_in  = '0;
         start_angle_in = '0;
      end else if (too_fast) begin
         armed_in  = 1'b0;
         stable_in = 1'b0;
      end else if (!armed_ff) begin
         armed_in       = 1'b1;
         start_time_in  = item.now_ms;
         start_angle_in = item.angle;
      end else begin
         // Nothing changes until the window has passed.
         if (window_done) begin
            if (angle_ok) begin
               if (!stable_ff) begin
                  stable_in     = 1'b1;
                  start_time_in = item.now_ms;
               end else if (hold_done) begin
                  locked = 1'b1;
               end
            end else begin
               stable_in      = 1'b0;
               start_time_in  = item.now_ms;
               start_angle_in = item.angle;
            end
         end
      end
   end

   // Result fields reflect the state after this beat.
   always_comb begin
      result.locked = locked;
      if (!armed_in) begin
         result.track_status = TRACK_IDLE;
      end else if (stable_in) begin
         result.track_status = TRACK_STABLE;
      end else begin
         result.track_status = TRACK_ARMED;
      end
   end

   // State moves only when a beat passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         stable_ff      <= 1'b0;
         start_time_ff  <= '0;
         start_angle_ff <= '0;
      end else if (advance) begin
         armed_ff       <= armed_in;
         stable_ff      <= stable_in;
         start_time_ff  <= start_time_in;
         start_angle_ff <= start_angle_in;
      end
   end

   // Stability is only ever tracked while armed.
   `ASSERT_IMPLIES(a_stable_needs_armed, clock, reset, stable_ff, armed_ff)
   // A clear beat leaves tracking fully reset.
   `ASSERT_NEXT(a_clear_resets, clock, reset, advance && item.clear,
                !armed_ff && !stable_ff && (start_time_ff == '0))
   // Lock is only reported from the stable holding state.
   `ASSERT_IMPLIES(a_locked_stable, clock, reset, result.locked,
                   stable_ff && (result.track_status == TRACK_STABLE))

endmodule

// ----- hw/rtl/stall_lock_detector_top.sv -----
// A sample accepted into the input register reaches rsp_ through the result register.
// Throughput: one sample per clock; the input register, the combinational decision in
// sld_core and the result register pass a beat on while the result side is not stalled.
// Reset (synchronous, active high) clears all valid flags and tracking state and
// returns the configuration registers to their defaults.
// Top level: holds the input and result registers around sld_core and sld_csr.
// Depends on sld_pkg, sld_csr, sld_core and assert_macros.svh.
`include "assert_macros.svh"
module stall_lock_detector_top
   import sld_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   logic    advance;
   rsp_type result;
   cfg_type cfg;

   sld_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sld_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // A beat moves on when the result register is empty or being emptied.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   // Input is held off only while a beat waits behind a stalled result.
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall,
                   in_valid_ff && out_valid_ff && rsp_stall)
   // Every beat that moves on appears as a result in the next cycle.
   `ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_valid)

endmodule

// ----- dv/stall_lock_detector_top_tb.sv -----
// Self-checking testbench for stall_lock_detector_top: telemetry samples in, lock results out.
// Depends on sld_pkg and the detector RTL; keeps its own model of the tracking state to
// predict each result.
`timescale 1ns / 100ps
module stall_lock_detector_top_tb;
   import sld_pkg::*;

   localparam int    HALF_PERIOD_NS = 6;
   localparam int    RESET_CYCLES   = 4;
   localparam int    DRAIN_BOUND    = 2000;
   localparam int    TAIL_CYCLES    = 4;
   localparam longint RUN_LIMIT_NS  = 4_000_000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   // Samples waiting to be driven and results waiting to be seen.
   req_type pending_samples[$];
   rsp_type expected_results[$];

   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int          mismatch_count = 0;

   // Mirror of the configuration registers.
   bit [14:0] cfg_threshold = SPEED_THRESHOLD_RST;
   bit [15:0] cfg_window    = WINDOW_MS_RST;
   bit [15:0] cfg_delta     = ANGLE_DELTA_MAX_RST;
   bit [15:0] cfg_hold      = HOLD_MS_RST;

   // Mirror of the tracking state.
   bit        trk_armed  = 1'b0;
   bit        trk_stable = 1'b0;
   bit [31:0] trk_since  = '0;
   int        trk_origin = 0;

   // Millisecond clock used when building sample sequences.
   bit [31:0] sample_ms = '0;

   stall_lock_detector_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Advances the tracking state by one sample and returns the result it should give.
   function automatic rsp_type advance_lock_tracker(input req_type s);
      rsp_type   r;
      int        spd;
      int        ang;
      int        d;
      bit [31:0] mag;
      bit [31:0] ad;
      bit [31:0] elapsed;
      r.locked = 1'b0;
      if (s.clear) begin
         trk_armed  = 1'b0;
         trk_stable = 1'b0;
         trk_since  = '0;
         trk_origin = 0;
      end else begin
         spd = $signed(s.speed);
         ang = $signed(s.angle);
         mag = (spd < 0) ? -spd : spd;
         if (mag > cfg_threshold) begin
            trk_armed  = 1'b0;
            trk_stable = 1'b0;
         end else if (!trk_armed) begin
            trk_armed  = 1'b1;
            trk_since  = s.now_ms;
            trk_origin = ang;
         end else begin
            elapsed = s.now_ms - trk_since;
            if (elapsed >= cfg_window) begin
               d  = ang - trk_origin;
               ad = (d < 0) ? -d : d;
               if (ad <= cfg_delta) begin
                  if (!trk_stable) begin
                     trk_stable = 1'b1;
                     trk_since  = s.now_ms;
                  end else if (elapsed >= cfg_hold) begin
                     r.locked = 1'b1;
                  end
               end else begin
                  // Shaft moved too far: restart tracking from this sample.
                  trk_stable = 1'b0;
                  trk_since  = s.now_ms;
                  trk_origin = ang;
               end
            end
         end
      end
      r.track_status = !trk_armed ? TRACK_IDLE : (trk_stable ? TRACK_STABLE : TRACK_ARMED);
      return r;
   endfunction

   // Sample driver: predicts each beat as it is accepted, then offers the next one.
   always @(posedge clock) begin : sample_driver
      req_type next_sample;
      logic    next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid  = req_valid;
         next_sample = req_payload;
         if (req_valid && !req_stall) begin
            expected_results.push_back(advance_lock_tracker(req_payload));
            next_valid = 1'b0;
         end
         if (!next_valid && pending_samples.size() > 0 &&
             $urandom_range(0, 99) >= req_idle_pct) begin
            next_sample = pending_samples.pop_front();
            next_valid  = 1'b1;
         end
         req_valid   <= next_valid;
         req_payload <= next_sample;
      end
   end

   // Result monitor: checks each accepted beat against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with no sample outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.locked !== want.locked)
                  report_mismatch($sformatf("locked %b, expected %b",
                                            rsp_payload.locked, want.locked));
               if (rsp_payload.track_status !== want.track_status)
                  report_mismatch($sformatf("track_status %0d, expected %0d",
                                            rsp_payload.track_status, want.track_status));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SPEED_THRESHOLD: cfg_threshold = value[14:0];
         CSR_WINDOW_MS:       cfg_window    = value;
         CSR_ANGLE_DELTA_MAX: cfg_delta     = value;
         CSR_HOLD_MS:         cfg_hold      = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [15:0] thr, input logic [15:0] win,
                               input logic [15:0] delta, input logic [15:0] hold);
      write_register(CSR_SPEED_THRESHOLD, thr);
      write_register(CSR_WINDOW_MS, win);
      write_register(CSR_ANGLE_DELTA_MAX, delta);
      write_register(CSR_HOLD_MS, hold);
   endtask

   task automatic queue_sample(input logic signed [15:0] spd, input logic signed [23:0] ang,
                               input logic [31:0] now, input logic clr);
      req_type s;
      s.speed  = spd;
      s.angle  = ang;
      s.now_ms = now;
      s.clear  = clr;
      pending_samples.push_back(s);
   endtask

   // Waits until every sample is accepted and every result seen, then lets the pipe settle.
   task automatic wait_drained();
      int waited;
      waited = 0;
      while (pending_samples.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
         expected_results.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Edge cases around the reset configuration: speed limits, window and hold boundaries,
   // timestamp wrap, re-arming after a large move, and clear.
   task automatic queue_directed();
      bit [31:0] t0;
      t0 = 32'hFFFF_FF00;
      queue_sample(16'(-32768), 24'(-8388608), 32'h0, 1'b0);
      queue_sample(16'(32767), 24'(8388607), 32'hFFFF_FFFF, 1'b0);
      queue_sample(16'(-32768), 24'(8388607), 32'hFFFF_FFFF, 1'b1);
      queue_sample(16'(51), 24'(0), 32'd5, 1'b0);
      queue_sample(16'(-51), 24'(0), 32'd5, 1'b0);
      queue_sample(16'(50), 24'(8388607), t0, 1'b0);
      queue_sample(16'(-50), 24'(8388557), t0 + 100, 1'b0);
      queue_sample(16'(0), 24'(8388557), t0 + 200, 1'b0);
      queue_sample(16'(10), 24'(8388607), t0 + 300, 1'b0);
      queue_sample(16'(10), 24'(8388600), t0 + 699, 1'b0);
      queue_sample(16'(10), 24'(8388600), t0 + 700, 1'b0);
      queue_sample(16'(-50), 24'(8388557), t0 + 900, 1'b0);
      queue_sample(16'(0), 24'(8388556), t0 + 1000, 1'b0);
      queue_sample(16'(0), 24'(8388556), t0 + 1200, 1'b0);
      queue_sample(16'(0), 24'(8388556), t0 + 1800, 1'b0);
      queue_sample(16'(32767), 24'(0), t0 + 1900, 1'b0);
      queue_sample(16'(0), 24'(-8388608), 32'd1000, 1'b0);
      queue_sample(16'(0), 24'(8388607), 32'd1300, 1'b0);
      queue_sample(16'(-1), 24'(-1), 32'hFFFF_FFFF, 1'b1);
      queue_sample(16'(0), 24'(0), 32'h0, 1'b0);
   endtask

   // Mostly runs of slow samples with jittered angles, mixed with random noise and clears.
   task automatic queue_random(input int count);
      int          made;
      int          len;
      int          base;
      int          jitter;
      int          mag;
      int unsigned span;
      int unsigned pick;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         span = (cfg_window > cfg_hold) ? 32'(cfg_window) : 32'(cfg_hold);
         if (pick < 70) begin
            len  = $urandom_range(3, 30);
            base = $signed(24'($urandom()));
            if ($urandom_range(0, 9) == 0)
               sample_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * span + 10);
            for (int i = 0; i < len; i++) begin
               sample_ms += $urandom_range(0, span / 4 + 2);
               // Speed: mostly at or below the threshold, sometimes just over or far over.
               if ($urandom_range(0, 9) != 0)
                  mag = ($urandom_range(0, 9) == 0) ? int'(cfg_threshold)
                                                    : int'($urandom_range(0, cfg_threshold));
               else
                  mag = $urandom_range(cfg_threshold + 1, 32768);
               if ($urandom_range(0, 1)) mag = -mag;
               // Angle: jitter within the limit, on its edges, just past them, or well beyond.
               case ($urandom_range(0, 9))
                  0:       jitter = $urandom_range(0, 1) ? int'(cfg_delta) : -int'(cfg_delta);
                  1:       jitter = $urandom_range(0, 1) ? int'(cfg_delta) + 1
                                                         : -int'(cfg_delta) - 1;
                  2:       jitter = $signed(24'($urandom()));
                  default: jitter = int'($urandom_range(0, 2 * cfg_delta)) - int'(cfg_delta);
               endcase
               queue_sample(16'(mag), 24'(base + jitter), sample_ms,
                            $urandom_range(0, 49) == 0);
               made++;
            end
         end else if (pick < 88) begin
            queue_sample(16'($urandom()), 24'($urandom()), $urandom(),
                         $urandom_range(0, 7) == 0);
            made++;
         end else begin
            queue_sample(16'($urandom()), 24'($urandom()), $urandom(), 1'b1);
            made++;
         end
      end
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int count);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      queue_random(count);
      wait_drained();
   endtask

   // Stimulus sequence: directed checks, then random phases under varied settings.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_directed();
      run_phase(0, 0, 250);

      apply_config(16'd0, 16'd0, 16'd0, 16'd0);
      run_phase(72, 0, 275);

      apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(0, 72, 275);

      apply_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 2000)), 16'($urandom_range(0, 600)));
      run_phase(12, 12, 275);

      apply_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 40)),
                   16'($urandom_range(0, 100)), 16'($urandom_range(0, 80)));
      run_phase(0, 0, 275);

      apply_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1000)));
      run_phase(72, 0, 275);

      apply_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 500)),
                   16'($urandom_range(0, 500)), 16'($urandom_range(0, 500)));
      run_phase(0, 72, 275);

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
